@@ sv/mpe_pkg.sv @@
// Shared types and constants for the mouse packet event decoder.
// No dependencies; every other file of the block imports this package.
package mpe_pkg;

  localparam int DELTA_W   = 9;
  localparam int BUTTON_W  = 2;
  localparam int NUM_BTN   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Event kinds
  localparam logic EV_MOTION = 1'b0;
  localparam logic EV_PRESS  = 1'b1;

  // Button codes
  localparam logic [BUTTON_W-1:0] BTN_LEFT   = 2'd0;
  localparam logic [BUTTON_W-1:0] BTN_RIGHT  = 2'd1;
  localparam logic [BUTTON_W-1:0] BTN_MIDDLE = 2'd2;

  // Packet byte positions
  localparam logic [1:0] IDX_HEADER = 2'd0;
  localparam logic [1:0] IDX_X      = 2'd1;

  // Header bit positions
  localparam int HDR_SIGN_X = 4;
  localparam int HDR_SIGN_Y = 5;

  // Decoded packet passed from the front to the back
  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic                      motion;
    logic [NUM_BTN-1:0]        buttons;
  } mpe_pkt_t;

endpackage

@@ sv/mpe_if.sv @@
// Handshake channels of the mouse packet event decoder: received bytes in,
// decoded events out. Depends on mpe_pkg.
interface mpe_byte_if;
  import mpe_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpe_event_if;
  import mpe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      event_kind;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic [BUTTON_W-1:0]       button;
  logic                      last;

  modport source (output valid, output event_kind, output delta_x, output delta_y,
                  output button, output last, input ready);
  modport sink   (input valid, input event_kind, input delta_x, input delta_y,
                  input button, input last, output ready);
endinterface

@@ sv/mouse_packet_event_decoder.sv @@
// Top level of the mouse packet event decoder: front end, packet queue and
// event back end. Depends on mpe_pkg, mpe_if, mpe_front, mpe_queue, mpe_back.
//
//   channel    | dir | payload                                       | beat
//   -----------+-----+-----------------------------------------------+---------------
//   in_ch      | in  | rx_byte[7:0]                                  | valid & ready
//   out_ch     | out | event_kind, delta_x, delta_y, button, last    | valid & ready
//   cfg        | in  | cfg_data (enable)                             | cfg_write
//
// A byte is taken on each valid & ready beat; first and second bytes never stall.
// A completing byte waits only while the two-entry packet queue is full.
// The back end loads a packet while it has no pending events, then issues one
// event per cycle from its output register while the event channel is not stalled.
// Synchronous reset clears enable, packet position, queue and output valid.
module mouse_packet_event_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  mpe_byte_if.sink    in_ch,
  mpe_event_if.source out_ch
);
  import mpe_pkg::*;

  logic     push;
  logic     pop;
  logic     full;
  logic     empty;
  mpe_pkt_t push_pkt;
  mpe_pkt_t pop_pkt;

  // Collect and classify bytes
  mpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .push      (push),
    .push_pkt  (push_pkt),
    .full      (full)
  );

  // Decouple front and back
  mpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (full),
    .pop      (pop),
    .pop_pkt  (pop_pkt),
    .empty    (empty)
  );

  // Issue events
  mpe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .pop     (pop),
    .pop_pkt (pop_pkt),
    .empty   (empty),
    .out_ch  (out_ch)
  );

endmodule

@@ sv/mpe_front.sv @@
// Front end: takes received bytes, collects three-byte packets and pushes
// decoded packets that carry motion or a button. Depends on mpe_pkg, mpe_if.
module mpe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_data,
  mpe_byte_if.sink         in_ch,
  output logic             push,
  output mpe_pkg::mpe_pkt_t push_pkt,
  input  logic             full
);
  import mpe_pkg::*;

  logic       enable;
  logic [1:0] byte_index;
  logic [7:0] header_byte;
  logic [7:0] x_byte;
  logic       accept;
  logic       completes;

  // Stall only a completing byte while the queue has no room
  assign completes   = byte_index[1];
  assign in_ch.ready = !enable || !completes || !full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Form deltas from the stored bytes and the current Y byte
  always_comb begin
    push_pkt.dx      = {header_byte[HDR_SIGN_X], x_byte};
    push_pkt.dy      = {header_byte[HDR_SIGN_Y], in_ch.rx_byte};
    push_pkt.motion  = (push_pkt.dx != '0) || (push_pkt.dy != '0);
    push_pkt.buttons = header_byte[NUM_BTN-1:0];
  end

  // Drop quiet packets
  assign push = accept && enable && completes && (push_pkt.motion || (|push_pkt.buttons));

  // Hold enable and advance the packet position
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      byte_index <= IDX_HEADER;
    end else begin
      if (cfg_write) begin
        enable <= cfg_data;
      end
      if (accept && enable) begin
        if (completes) begin
          byte_index <= IDX_HEADER;
        end else begin
          byte_index <= byte_index + 2'd1;
        end
      end
    end
  end

  // Store header and X bytes
  always_ff @(posedge clk) begin
    if (accept && enable && !completes) begin
      if (byte_index == IDX_HEADER) begin
        header_byte <= in_ch.rx_byte;
      end else begin
        x_byte <= in_ch.rx_byte;
      end
    end
  end

endmodule

@@ sv/mpe_queue.sv @@
// Short packet queue between the front and back ends.
// Depends on mpe_pkg.
module mpe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mpe_pkg::mpe_pkt_t push_pkt,
  output logic              full,
  input  logic              pop,
  output mpe_pkg::mpe_pkt_t pop_pkt,
  output logic              empty
);
  import mpe_pkg::*;

  mpe_pkt_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_pkt = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Write packet storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

endmodule

@@ sv/mpe_back.sv @@
// Back end: loads a packet from the queue and issues its events one beat at
// a time through an output register. Depends on mpe_pkg, mpe_if.
module mpe_back (
  input  logic              clk,
  input  logic              rst,
  output logic              pop,
  input  mpe_pkg::mpe_pkt_t pop_pkt,
  input  logic              empty,
  mpe_event_if.source       out_ch
);
  import mpe_pkg::*;

  logic                      pend_motion;
  logic [NUM_BTN-1:0]        pend_btn;
  logic signed [DELTA_W-1:0] cur_dx;
  logic signed [DELTA_W-1:0] cur_dy;
  logic                      busy;
  logic                      slot_free;
  logic                      emit;
  logic                      ev_kind;
  logic [BUTTON_W-1:0]       ev_button;
  logic                      pend_motion_next;
  logic [NUM_BTN-1:0]        pend_btn_next;

  assign busy      = pend_motion || (|pend_btn);
  assign slot_free = !out_ch.valid || out_ch.ready;
  assign emit      = busy && slot_free;
  assign pop       = !busy && !empty;

  // Pick the next event: motion first, then left, right, middle
  always_comb begin
    ev_kind          = EV_MOTION;
    ev_button        = BTN_LEFT;
    pend_motion_next = pend_motion;
    pend_btn_next    = pend_btn;
    if (pend_motion) begin
      pend_motion_next = 1'b0;
    end else if (pend_btn[0]) begin
      ev_kind          = EV_PRESS;
      ev_button        = BTN_LEFT;
      pend_btn_next[0] = 1'b0;
    end else if (pend_btn[1]) begin
      ev_kind          = EV_PRESS;
      ev_button        = BTN_RIGHT;
      pend_btn_next[1] = 1'b0;
    end else begin
      ev_kind          = EV_PRESS;
      ev_button        = BTN_MIDDLE;
      pend_btn_next[2] = 1'b0;
    end
  end

  // Hold pending work and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_motion  <= 1'b0;
      pend_btn     <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (pop) begin
        pend_motion <= pop_pkt.motion;
        pend_btn    <= pop_pkt.buttons;
      end else if (emit) begin
        pend_motion <= pend_motion_next;
        pend_btn    <= pend_btn_next;
      end
      if (emit) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Load deltas and the output beat payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_dx <= pop_pkt.dx;
      cur_dy <= pop_pkt.dy;
    end
    if (emit) begin
      out_ch.event_kind <= ev_kind;
      out_ch.delta_x    <= (ev_kind == EV_MOTION) ? cur_dx : '0;
      out_ch.delta_y    <= (ev_kind == EV_MOTION) ? cur_dy : '0;
      out_ch.button     <= (ev_kind == EV_MOTION) ? BTN_LEFT : ev_button;
      out_ch.last       <= !pend_motion_next && (pend_btn_next == '0);
    end
  end

endmodule

@@ test/tb_mouse_packet_event_decoder.sv @@
// Self-checking bench for the mouse packet event decoder: a directed table of
// bytes, then random packets, with every event checked against the table or a local decoder.
// Depends on mpe_pkg, mpe_if and mouse_packet_event_decoder.
module tb_mouse_packet_event_decoder;
  import mpe_pkg::*;

  localparam logic [1:0] IDX_Y = 2'd2;
  localparam int SETTLE        = 16;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_BYTES  = 405;
  localparam int MAX_PRINTS    = 40;
  localparam logic [BUTTON_W-1:0] BTN_OF_BIT [NUM_BTN] = '{BTN_LEFT, BTN_RIGHT, BTN_MIDDLE};

  typedef struct packed {
    logic                      kind;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [BUTTON_W-1:0]       btn;
    logic                      last;
  } mouse_ev_t;

  // One directed byte; nwant < 0 means the local decoder supplies the events
  typedef struct {
    bit         en;
    logic [7:0] data;
    int         nwant;
    mouse_ev_t  want [4];
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  mpe_byte_if  in_ch ();
  mpe_event_if out_ch ();

  mouse_packet_event_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Decoder state mirrored by the bench
  logic       decode_en;
  logic [1:0] pkt_pos;
  logic [7:0] hdr_copy;
  logic [7:0] x_copy;

  mouse_ev_t  fresh_events [$];
  mouse_ev_t  pending_events [$];
  stim_row_t  rows [$];
  logic [7:0] pkt_bytes [$];

  bit no_idle;
  int n_err;
  int hold_left;
  int quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    n_err++;
    if (n_err <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic mouse_ev_t mot(input logic [DELTA_W-1:0] dx, input logic [DELTA_W-1:0] dy,
                                    input logic last);
    mouse_ev_t ev;
    ev.kind = EV_MOTION;
    ev.dx   = dx;
    ev.dy   = dy;
    ev.btn  = '0;
    ev.last = last;
    return ev;
  endfunction

  function automatic mouse_ev_t prs(input logic [BUTTON_W-1:0] btn, input logic last);
    mouse_ev_t ev;
    ev.kind = EV_PRESS;
    ev.dx   = '0;
    ev.dy   = '0;
    ev.btn  = btn;
    ev.last = last;
    return ev;
  endfunction

  // Advance the mirrored state by one accepted byte; leave its events in fresh_events
  function automatic void decode_byte(input logic [7:0] b);
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    fresh_events.delete();
    if (!decode_en) return;
    if (pkt_pos == IDX_HEADER) begin
      hdr_copy = b;
      pkt_pos  = IDX_X;
      return;
    end
    if (pkt_pos == IDX_X) begin
      x_copy  = b;
      pkt_pos = IDX_Y;
      return;
    end
    pkt_pos = IDX_HEADER;
    dx = {hdr_copy[HDR_SIGN_X], x_copy};
    dy = {hdr_copy[HDR_SIGN_Y], b};
    if (dx != 0 || dy != 0) fresh_events.push_back(mot(dx, dy, 1'b0));
    for (int i = 0; i < NUM_BTN; i++) begin
      if (hdr_copy[i]) fresh_events.push_back(prs(BTN_OF_BIT[i], 1'b0));
    end
    if (fresh_events.size() > 0) fresh_events[fresh_events.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_row(input bit en, input logic [7:0] data, input int nwant = -1,
                                  input mouse_ev_t w0 = '0, input mouse_ev_t w1 = '0,
                                  input mouse_ev_t w2 = '0, input mouse_ev_t w3 = '0);
    stim_row_t r;
    r.en      = en;
    r.data    = data;
    r.nwant   = nwant;
    r.want[0] = w0;
    r.want[1] = w1;
    r.want[2] = w2;
    r.want[3] = w3;
    rows.push_back(r);
  endfunction

  function automatic logic [7:0] rand_move_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 8'h00;
    if (r < 4) return 8'hFF;
    if (r == 4) return 8'h80;
    if (r == 5) return 8'h7F;
    return 8'($urandom);
  endfunction

  // Queue one packet: mostly random movement, sometimes quiet or zero bytes
  function automatic void fill_packet();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      pkt_bytes.push_back(8'($urandom) & 8'hC8);
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'h00);
    end else if (r == 1) begin
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'h00);
    end else begin
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(rand_move_byte());
      pkt_bytes.push_back(rand_move_byte());
    end
  endfunction

  // Present one byte after a random gap and hold it until the beat
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drain all events, let the back end settle, then write the enable register
  task automatic set_enable(input logic v);
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    decode_en = v;
  endtask

  // Sink side: random stalls on the event channel
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      n = idle_len();
      out_ch.ready <= (n == 0);
      if (n > 0) hold_left <= n - 1;
    end
  end

  // Compare each event beat with the oldest expected event
  always @(posedge clk) begin
    mouse_ev_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event beat with none expected");
      end else begin
        w = pending_events.pop_front();
        if (out_ch.event_kind !== w.kind)
          report_mismatch($sformatf("event_kind %0d, expected %0d", out_ch.event_kind, w.kind));
        if (out_ch.delta_x !== w.dx)
          report_mismatch($sformatf("delta_x %0d, expected %0d", out_ch.delta_x, w.dx));
        if (out_ch.delta_y !== w.dy)
          report_mismatch($sformatf("delta_y %0d, expected %0d", out_ch.delta_y, w.dy));
        if (out_ch.button !== w.btn)
          report_mismatch($sformatf("button %0d, expected %0d", out_ch.button, w.btn));
        if (out_ch.last !== w.last)
          report_mismatch($sformatf("last %0d, expected %0d", out_ch.last, w.last));
      end
    end
  end

  // Watchdog: stop the run when no beat or write has happened for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int len;
    logic [7:0] b;
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_data      = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    no_idle       = 1'b0;
    n_err         = 0;
    quiet_cycles  = 0;
    hold_left     = 0;
    decode_en     = 1'b0;
    pkt_pos       = IDX_HEADER;
    hdr_copy      = 8'h00;
    x_copy        = 8'h00;
    sent          = 0;

    // Disabled after reset: bytes are dropped
    add_row(1'b0, 8'hFF, 0);
    add_row(1'b0, 8'h07, 0);
    // Quiet packet: nothing at all
    add_row(1'b1, 8'h00, 0);
    add_row(1'b1, 8'h00, 0);
    add_row(1'b1, 8'h00, 0);
    // Largest positive deltas with all three buttons
    add_row(1'b1, 8'h07, 0);
    add_row(1'b1, 8'hFF, 0);
    add_row(1'b1, 8'hFF, 4, mot(9'h0FF, 9'h0FF, 1'b0), prs(BTN_LEFT, 1'b0),
            prs(BTN_RIGHT, 1'b0), prs(BTN_MIDDLE, 1'b1));
    // Most negative deltas, motion only
    add_row(1'b1, 8'h30, 0);
    add_row(1'b1, 8'h00, 0);
    add_row(1'b1, 8'h00, 1, mot(9'h100, 9'h100, 1'b1));
    // Press without motion
    add_row(1'b1, 8'h01, 0);
    add_row(1'b1, 8'h00, 0);
    add_row(1'b1, 8'h00, 1, prs(BTN_LEFT, 1'b1));
    // Sync and overflow bits set, small X only
    add_row(1'b1, 8'hC8);
    add_row(1'b1, 8'h01);
    add_row(1'b1, 8'h00);
    // Packet broken by a disabled stretch, then resumed
    add_row(1'b1, 8'h12);
    add_row(1'b1, 8'h80);
    add_row(1'b0, 8'h55, 0);
    add_row(1'b0, 8'hAA, 0);
    add_row(1'b1, 8'h7F);
    // Only Y moves
    add_row(1'b1, 8'h20, 0);
    add_row(1'b1, 8'h00, 0);
    add_row(1'b1, 8'h00, 1, mot(9'h000, 9'h100, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (rows[i]) begin
      if (rows[i].en != decode_en) set_enable(rows[i].en);
      send_byte(rows[i].data);
      decode_byte(rows[i].data);
      if (rows[i].nwant < 0) begin
        foreach (fresh_events[k]) pending_events.push_back(fresh_events[k]);
      end else begin
        for (int k = 0; k < rows[i].nwant; k++) pending_events.push_back(rows[i].want[k]);
      end
    end

    // Random phases: mostly enabled packet streams, short disabled noise bursts
    while (sent < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 3) == 0);
      set_enable($urandom_range(0, 4) != 0);
      len = decode_en ? $urandom_range(10, 60) : $urandom_range(2, 8);
      repeat (len) begin
        if (decode_en) begin
          if (pkt_bytes.size() == 0) fill_packet();
          b = pkt_bytes.pop_front();
          sent++;
        end else begin
          b = 8'($urandom);
        end
        send_byte(b);
        decode_byte(b);
        foreach (fresh_events[k]) pending_events.push_back(fresh_events[k]);
      end
    end

    // Drop valid, drain and give late extra events a chance to show
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
